// File: hw/rtl/cot_pkg.sv
// types and constants shared by the countdown overtime timer modules
package cot_pkg;

    localparam int unsigned SEC_PER_MIN = 60;
    localparam int unsigned SLOTS       = 4;
    localparam int unsigned IDX_W       = 2;
    localparam int unsigned PLAN_W      = 22;
    localparam int unsigned ELAP_W      = 32;

    typedef enum logic [2:0] {
        OP_SET_TIME = 3'd0,
        OP_START    = 3'd1,
        OP_PAUSE    = 3'd2,
        OP_RESUME   = 3'd3,
        OP_STOP     = 3'd4,
        OP_RESET    = 3'd5,
        OP_TICK     = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_RUNNING  = 3'd1,
        MODE_PAUSED   = 3'd2,
        MODE_OVERTIME = 3'd3,
        MODE_FINISHED = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_CHANGE   = 2'd0,
        KIND_FEEDBACK = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_SLIP     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FB_START  = 2'd0,
        FB_STOP   = 2'd1,
        FB_RESET  = 2'd2,
        FB_TIMEUP = 2'd3
    } t_fb;

    typedef struct packed {
        t_kind kind;
        t_mode prev;
        t_mode next;
        t_fb   fb;
    } t_slot;

    typedef struct packed {
        t_slot [SLOTS-1:0]   slots;
        logic  [IDX_W-1:0]   last_idx;
        logic  [PLAN_W-1:0]  planned;
        logic  [ELAP_W-1:0]  elapsed;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

endpackage

// File: hw/rtl/cot_front.sv
// command decode, timer state and result list for each accepted command
module cot_front
    import cot_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_minutes,
    input  logic        i_room,
    output logic        o_ready,
    output t_push       o_push
);

    t_mode               r_mode, n_mode;
    t_mode               r_paused_from, n_paused_from;
    logic [PLAN_W-1:0]   r_planned, n_planned;
    logic [ELAP_W-1:0]   r_elapsed, n_elapsed;
    logic                w_cross;
    logic                w_accept;
    logic [2:0]          w_cnt;
    t_job                w_job;

    assign o_ready  = i_room;
    assign w_accept = i_valid && i_room;

    // next state
    always_comb begin
        n_mode        = r_mode;
        n_paused_from = r_paused_from;
        n_planned     = r_planned;
        n_elapsed     = r_elapsed;
        w_cross       = 1'b0;
        case (i_operation)
            OP_SET_TIME: begin
                if (r_mode == MODE_IDLE) begin
                    n_planned = PLAN_W'(i_minutes * PLAN_W'(SEC_PER_MIN));
                end
            end
            OP_START: begin
                if (r_mode == MODE_IDLE && r_planned != '0) begin
                    n_elapsed = '0;
                    n_mode    = MODE_RUNNING;
                end
            end
            OP_PAUSE: begin
                if (r_mode == MODE_RUNNING || r_mode == MODE_OVERTIME) begin
                    n_paused_from = r_mode;
                    n_mode        = MODE_PAUSED;
                end
            end
            OP_RESUME: begin
                if (r_mode == MODE_PAUSED) begin
                    n_mode = r_paused_from;
                end
            end
            OP_STOP: begin
                if (r_mode inside {MODE_RUNNING, MODE_OVERTIME, MODE_PAUSED}) begin
                    n_mode = MODE_IDLE;
                end
            end
            OP_RESET: begin
                n_planned = '0;
                n_elapsed = '0;
                n_mode    = MODE_IDLE;
            end
            OP_TICK: begin
                if (r_mode == MODE_RUNNING || r_mode == MODE_OVERTIME) begin
                    if (r_elapsed != '1) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                    if (r_mode == MODE_RUNNING &&
                        n_elapsed >= ELAP_W'(r_planned)) begin
                        w_cross = 1'b1;
                        n_mode  = MODE_OVERTIME;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result list
    always_comb begin
        w_job         = '0;
        w_cnt         = 3'd0;
        w_job.planned = n_planned;
        w_job.elapsed = n_elapsed;
        case (i_operation)
            OP_SET_TIME: begin
                if (r_mode == MODE_IDLE) begin
                    w_job.slots[0].kind = KIND_TICK;
                    w_cnt = 3'd1;
                end
            end
            OP_START: begin
                if (r_mode == MODE_IDLE && r_planned != '0) begin
                    w_job.slots[0].kind = KIND_CHANGE;
                    w_job.slots[0].prev = MODE_IDLE;
                    w_job.slots[0].next = MODE_RUNNING;
                    w_job.slots[1].kind = KIND_FEEDBACK;
                    w_job.slots[1].fb   = FB_START;
                    w_job.slots[2].kind = KIND_TICK;
                    w_cnt = 3'd3;
                end
            end
            OP_PAUSE: begin
                if (r_mode == MODE_RUNNING || r_mode == MODE_OVERTIME) begin
                    w_job.slots[0].kind = KIND_CHANGE;
                    w_job.slots[0].prev = r_mode;
                    w_job.slots[0].next = MODE_PAUSED;
                    w_cnt = 3'd1;
                end
            end
            OP_RESUME: begin
                if (r_mode == MODE_PAUSED) begin
                    w_job.slots[0].kind = KIND_CHANGE;
                    w_job.slots[0].prev = MODE_PAUSED;
                    w_job.slots[0].next = r_paused_from;
                    w_cnt = 3'd1;
                end
            end
            OP_STOP: begin
                if (r_mode inside {MODE_RUNNING, MODE_OVERTIME, MODE_PAUSED}) begin
                    w_job.slots[0].kind = KIND_CHANGE;
                    w_job.slots[0].prev = r_mode;
                    w_job.slots[0].next = MODE_FINISHED;
                    w_job.slots[1].kind = KIND_FEEDBACK;
                    w_job.slots[1].fb   = FB_STOP;
                    w_job.slots[2].kind = KIND_SLIP;
                    w_job.slots[3].kind = KIND_CHANGE;
                    w_job.slots[3].prev = MODE_FINISHED;
                    w_job.slots[3].next = MODE_IDLE;
                    w_cnt = 3'd4;
                end
            end
            OP_RESET: begin
                w_job.slots[0].kind = KIND_FEEDBACK;
                w_job.slots[0].fb   = FB_RESET;
                if (r_mode != MODE_IDLE) begin
                    w_job.slots[1].kind = KIND_CHANGE;
                    w_job.slots[1].prev = r_mode;
                    w_job.slots[1].next = MODE_IDLE;
                    w_job.slots[2].kind = KIND_TICK;
                    w_cnt = 3'd3;
                end else begin
                    w_job.slots[1].kind = KIND_TICK;
                    w_cnt = 3'd2;
                end
            end
            OP_TICK: begin
                if (r_mode == MODE_RUNNING || r_mode == MODE_OVERTIME) begin
                    if (w_cross) begin
                        w_job.slots[0].kind = KIND_CHANGE;
                        w_job.slots[0].prev = MODE_RUNNING;
                        w_job.slots[0].next = MODE_OVERTIME;
                        w_job.slots[1].kind = KIND_FEEDBACK;
                        w_job.slots[1].fb   = FB_TIMEUP;
                        w_job.slots[2].kind = KIND_TICK;
                        w_cnt = 3'd3;
                    end else begin
                        w_job.slots[0].kind = KIND_TICK;
                        w_cnt = 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        w_job.last_idx = IDX_W'(w_cnt - 3'd1);
    end

    assign o_push.push = w_accept && (w_cnt != 3'd0);
    assign o_push.job  = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_paused_from <= MODE_RUNNING;
            r_planned     <= '0;
            r_elapsed     <= '0;
        end else if (w_accept) begin
            r_mode        <= n_mode;
            r_paused_from <= n_paused_from;
            r_planned     <= n_planned;
            r_elapsed     <= n_elapsed;
        end
    end

endmodule

// File: hw/rtl/cot_queue.sv
// short queue of result lists between front and back
module cot_queue
    import cot_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_room,
    output logic  o_avail,
    output t_job  o_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_wr, w_rd;

    assign o_room  = (r_count != CNT_W'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_wr    = i_push.push && o_room;
    assign w_rd    = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/cot_back.sv
// result sequencer: walks one result list and shows one beat per cycle while the output is ready
module cot_back
    import cot_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_kind,
    output logic [2:0]          o_prev_mode,
    output logic [2:0]          o_next_mode,
    output logic [1:0]          o_feedback_code,
    output logic [PLAN_W-1:0]   o_planned_sec,
    output logic [ELAP_W-1:0]   o_elapsed_sec,
    output logic [PLAN_W-1:0]   o_remaining_sec,
    output logic [ELAP_W-1:0]   o_overrun_sec,
    output logic                o_last
);

    logic              r_busy;
    t_job              r_job;
    logic [IDX_W-1:0]  r_idx;
    t_slot             w_slot;
    logic              w_last, w_take, w_tick, w_slip;
    logic [ELAP_W-1:0] w_plan32;

    assign w_slot   = r_job.slots[r_idx];
    assign w_last   = (r_idx == r_job.last_idx);
    assign w_take   = !r_busy || (i_ready && w_last);
    assign o_pop    = w_take && i_avail;
    assign o_valid  = r_busy;
    assign w_tick   = (w_slot.kind == KIND_TICK);
    assign w_slip   = (w_slot.kind == KIND_SLIP);
    assign w_plan32 = ELAP_W'(r_job.planned);

    always_comb begin
        o_kind          = w_slot.kind;
        o_prev_mode     = w_slot.prev;
        o_next_mode     = w_slot.next;
        o_feedback_code = w_slot.fb;
        o_last          = w_last;
        o_planned_sec   = (w_tick || w_slip) ? r_job.planned : '0;
        o_elapsed_sec   = (w_tick || w_slip) ? r_job.elapsed : '0;
        o_remaining_sec = (w_tick && r_job.elapsed < w_plan32) ?
                          PLAN_W'(w_plan32 - r_job.elapsed) : '0;
        o_overrun_sec   = ((w_tick || w_slip) && r_job.elapsed > w_plan32) ?
                          (r_job.elapsed - w_plan32) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_take) begin
            r_busy <= i_avail;
            r_idx  <= '0;
        end else if (i_ready) begin
            r_idx  <= r_idx + 1'b1;
        end
    end

endmodule

// File: hw/rtl/countdown_overtime_timer.sv
// countdown timer with pause and overtime: command front, list queue, result back
// the first result of a command is registered in the queue, then in the result sequencer, before it is valid
// throughput: a command beat every cycle while the queue has room; the result
// sequencer gives one beat per cycle while the output is ready, 1 to 4 beats a command
// ignored commands are accepted but give no results
// synchronous active-low reset: idle, no plan, nothing elapsed, queue empty
module countdown_overtime_timer
    import cot_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [2:0]   i_operation,
    input  logic [15:0]  i_minutes,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [1:0]   o_kind,
    output logic [2:0]   o_prev_mode,
    output logic [2:0]   o_next_mode,
    output logic [1:0]   o_feedback_code,
    output logic [21:0]  o_planned_sec,
    output logic [31:0]  o_elapsed_sec,
    output logic [21:0]  o_remaining_sec,
    output logic [31:0]  o_overrun_sec,
    output logic         o_last
);

    t_push w_push;
    t_job  w_job;
    logic  w_room, w_avail, w_pop;

    cot_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_operation (i_operation),
        .i_minutes   (i_minutes),
        .i_room      (w_room),
        .o_ready     (o_in_ready),
        .o_push      (w_push)
    );

    cot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_avail (w_avail),
        .o_job   (w_job)
    );

    cot_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (w_avail),
        .i_job           (w_job),
        .o_pop           (w_pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_kind          (o_kind),
        .o_prev_mode     (o_prev_mode),
        .o_next_mode     (o_next_mode),
        .o_feedback_code (o_feedback_code),
        .o_planned_sec   (o_planned_sec),
        .o_elapsed_sec   (o_elapsed_sec),
        .o_remaining_sec (o_remaining_sec),
        .o_overrun_sec   (o_overrun_sec),
        .o_last          (o_last)
    );

endmodule

// File: hw/rtl/cot_checker.sv
// port-level checks for the countdown overtime timer, bound to the top level
module cot_checker
    import cot_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input logic [1:0]   o_kind,
    input logic [2:0]   o_prev_mode,
    input logic [2:0]   o_next_mode,
    input logic [21:0]  o_remaining_sec,
    input logic [31:0]  o_overrun_sec,
    input logic         o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_last) && $stable(o_overrun_sec))
        else $error("stalled output beat changed");

    a_change_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_CHANGE |-> o_prev_mode != o_next_mode)
        else $error("state change beat without a change");

    a_rem_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_remaining_sec == '0 || o_overrun_sec == '0))
        else $error("remaining and overrun both nonzero");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind countdown_overtime_timer cot_checker u_cot_checker (.*);

// File: tb/testbench.sv
// self-checking testbench for the countdown overtime timer: command sequences against a predictor
`timescale 1ns / 100ps

module testbench;
    import cot_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    typedef struct packed {
        t_kind             kind;
        t_mode             prev;
        t_mode             next;
        t_fb               fb;
        logic [PLAN_W-1:0] planned;
        logic [ELAP_W-1:0] elapsed;
        logic [PLAN_W-1:0] remaining;
        logic [ELAP_W-1:0] overrun;
        logic              last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_operation = 3'd0;
    logic [15:0] i_minutes = 16'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [2:0]  o_prev_mode;
    logic [2:0]  o_next_mode;
    logic [1:0]  o_feedback_code;
    logic [21:0] o_planned_sec;
    logic [31:0] o_elapsed_sec;
    logic [21:0] o_remaining_sec;
    logic [31:0] o_overrun_sec;
    logic        o_last;

    countdown_overtime_timer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_minutes       (i_minutes),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_prev_mode     (o_prev_mode),
        .o_next_mode     (o_next_mode),
        .o_feedback_code (o_feedback_code),
        .o_planned_sec   (o_planned_sec),
        .o_elapsed_sec   (o_elapsed_sec),
        .o_remaining_sec (o_remaining_sec),
        .o_overrun_sec   (o_overrun_sec),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    // timer state as predicted
    t_mode             timer_mode = MODE_IDLE;
    t_mode             timer_paused_from = MODE_RUNNING;
    logic [PLAN_W-1:0] timer_plan = '0;
    logic [ELAP_W-1:0] timer_elapsed = '0;

    t_beat expected_beats[$];
    t_beat step_beats[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int failures = 0;
    int commands_sent = 0;
    int productive_items = 0;
    int beats_checked = 0;
    int timeups_predicted = 0;
    int input_stalls = 0;
    int cycle_count = 0;

    function automatic t_beat blank_beat(t_kind k);
        t_beat b;
        b = '0;
        b.kind = k;
        return b;
    endfunction

    function automatic string beat_str(t_beat b);
        return $sformatf({"kind=%0d prev=%0d next=%0d fb=%0d plan=%0d elap=%0d",
                          " rem=%0d over=%0d last=%0d"},
                         b.kind, b.prev, b.next, b.fb, b.planned, b.elapsed, b.remaining,
                         b.overrun, b.last);
    endfunction

    function automatic logic [ELAP_W-1:0] overrun_now();
        return (timer_elapsed > ELAP_W'(timer_plan)) ? timer_elapsed - ELAP_W'(timer_plan) : '0;
    endfunction

    task automatic note_change(t_mode nxt);
        t_beat b;
        if (nxt != timer_mode) begin
            b = blank_beat(KIND_CHANGE);
            b.prev = timer_mode;
            b.next = nxt;
            step_beats.push_back(b);
            timer_mode = nxt;
        end
    endtask

    task automatic note_feedback(t_fb code);
        t_beat b;
        b = blank_beat(KIND_FEEDBACK);
        b.fb = code;
        step_beats.push_back(b);
    endtask

    task automatic note_tick();
        t_beat b;
        b = blank_beat(KIND_TICK);
        b.planned = timer_plan;
        b.elapsed = timer_elapsed;
        b.remaining = (timer_elapsed < ELAP_W'(timer_plan)) ?
                      PLAN_W'(ELAP_W'(timer_plan) - timer_elapsed) : '0;
        b.overrun = overrun_now();
        step_beats.push_back(b);
    endtask

    task automatic predict_command(input logic [2:0] op, input logic [15:0] mins, output int n);
        t_beat b;
        step_beats.delete();
        case (op)
            OP_SET_TIME: begin
                if (timer_mode == MODE_IDLE) begin
                    timer_plan = PLAN_W'(32'(mins) * SEC_PER_MIN);
                    note_tick();
                end
            end
            OP_START: begin
                if (timer_mode == MODE_IDLE && timer_plan != '0) begin
                    timer_elapsed = '0;
                    note_change(MODE_RUNNING);
                    note_feedback(FB_START);
                    note_tick();
                end
            end
            OP_PAUSE: begin
                if (timer_mode == MODE_RUNNING || timer_mode == MODE_OVERTIME) begin
                    timer_paused_from = timer_mode;
                    note_change(MODE_PAUSED);
                end
            end
            OP_RESUME: begin
                if (timer_mode == MODE_PAUSED) note_change(timer_paused_from);
            end
            OP_STOP: begin
                if (timer_mode == MODE_RUNNING || timer_mode == MODE_OVERTIME ||
                    timer_mode == MODE_PAUSED) begin
                    note_change(MODE_FINISHED);
                    note_feedback(FB_STOP);
                    b = blank_beat(KIND_SLIP);
                    b.planned = timer_plan;
                    b.elapsed = timer_elapsed;
                    b.overrun = overrun_now();
                    step_beats.push_back(b);
                    note_change(MODE_IDLE);
                end
            end
            OP_RESET: begin
                timer_plan = '0;
                timer_elapsed = '0;
                note_feedback(FB_RESET);
                note_change(MODE_IDLE);
                note_tick();
            end
            OP_TICK: begin
                if (timer_mode == MODE_RUNNING || timer_mode == MODE_OVERTIME) begin
                    if (timer_elapsed != '1) timer_elapsed = timer_elapsed + 1'b1;
                    if (timer_mode == MODE_RUNNING && timer_elapsed >= ELAP_W'(timer_plan)) begin
                        note_change(MODE_OVERTIME);
                        note_feedback(FB_TIMEUP);
                        timeups_predicted++;
                    end
                    note_tick();
                end
            end
            default: ;
        endcase
        n = step_beats.size();
        if (n > 0) step_beats[n-1].last = 1'b1;
        foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    endtask

    // called in the time step of a rising edge; returns in the step of acceptance
    task automatic send_command(input logic [2:0] op, input logic [15:0] mins);
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_minutes   <= mins;
        predict_command(op, mins, n);
        commands_sent++;
        if (n > 0) productive_items++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
    endtask

    // an optional reset, set, start, a body of mostly ticks with pauses and noise, then a stop, a reset or neither
    task automatic run_session(input int body_len);
        int r;
        logic [15:0] mins;
        if ($urandom_range(99) < 30) send_command(OP_RESET, 16'($urandom));
        r = $urandom_range(99);
        mins = (r < 70) ? 16'd1 : (r < 88) ? 16'($urandom) : 16'd0;
        send_command(OP_SET_TIME, mins);
        send_command(OP_START, 16'($urandom));
        repeat (body_len) begin
            r = $urandom_range(99);
            if (r < 78) send_command(OP_TICK, 16'($urandom));
            else if (r < 85) send_command(OP_PAUSE, 16'($urandom));
            else if (r < 91) send_command(OP_RESUME, 16'($urandom));
            else if (r < 96) send_command(3'($urandom), 16'($urandom));
            else send_command(r[0] ? OP_SET_TIME : OP_START, 16'($urandom));
        end
        r = $urandom_range(99);
        if (r < 70) send_command(OP_STOP, 16'($urandom));
        else if (r < 90) send_command(OP_RESET, 16'($urandom));
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_command(OP_RESET, 16'd0);
        send_command(OP_START, 16'd0);
        send_command(OP_PAUSE, 16'd0);
        send_command(OP_RESUME, 16'd0);
        send_command(OP_STOP, 16'd0);
        send_command(OP_TICK, 16'd0);
        send_command(3'd7, 16'hFFFF);
        send_command(OP_SET_TIME, 16'hFFFF);
        send_command(OP_SET_TIME, 16'h0000);
        send_command(OP_SET_TIME, 16'd1);
        send_command(OP_START, 16'd0);
        send_command(OP_SET_TIME, 16'd3);
        send_command(OP_START, 16'd0);
        send_command(OP_RESUME, 16'd0);
        send_command(OP_TICK, 16'd0);
        send_command(OP_TICK, 16'd0);
        send_command(OP_PAUSE, 16'd0);
        send_command(OP_TICK, 16'd0);
        send_command(OP_PAUSE, 16'd0);
        send_command(OP_RESUME, 16'd0);
        send_command(OP_STOP, 16'd0);
        send_command(OP_START, 16'd0);
        send_command(OP_PAUSE, 16'd0);
        send_command(OP_STOP, 16'd0);
        send_command(OP_START, 16'd0);
        send_command(OP_RESET, 16'd0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 400;
        send_command(OP_RESET, 16'd0);
        send_command(OP_SET_TIME, 16'd1);
        send_command(OP_START, 16'd0);
        repeat (12) send_command(OP_TICK, 16'($urandom));
        send_command(OP_STOP, 16'd0);
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int items);
        int goal;
        int left;
        int len;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        goal = commands_sent + items;
        while (commands_sent < goal) begin
            left = goal - commands_sent;
            if ($urandom_range(99) < 25) len = $urandom_range(3, 15);
            else len = $urandom_range(50, 90);
            if (len > left) len = left;
            run_session(len);
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n && i_in_valid && !o_in_ready) input_stalls++;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind      = t_kind'(o_kind);
            got.prev      = t_mode'(o_prev_mode);
            got.next      = t_mode'(o_next_mode);
            got.fb        = t_fb'(o_feedback_code);
            got.planned   = o_planned_sec;
            got.elapsed   = o_elapsed_sec;
            got.remaining = o_remaining_sec;
            got.overrun   = o_overrun_sec;
            got.last      = o_last;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected beat: %s", beat_str(got));
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("mismatch at beat %0d", beats_checked);
                        $display("  expected %s", beat_str(want));
                        $display("  actual   %s", beat_str(got));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     expected_beats.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_phase(0, 0, 70);
        test_random_phase(70, 0, 70);
        test_random_phase(0, 70, 70);
        test_random_phase(34, 34, 70);
        repeat (20) @(posedge i_clk);
        failures += expected_beats.size();
        $display("covered %0d commands (%0d with results) and %0d result beats",
                 commands_sent, productive_items, beats_checked);
        $display("overtime entries %0d, input stall cycles %0d, failures %0d", timeups_predicted,
                 input_stalls, failures);
        if (failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
